@@ hdl/kwm_pkg.sv @@
`default_nettype none

package kwm_pkg;

  // Widths fixed by the item fields and the register.
  localparam int SRC_W = 4;
  localparam int VAL_W = 32;
  localparam int CFG_W = 5;

  // Source is four bits wide, so no more than this many lists can take part.
  localparam int SRC_SPAN = 16;
  localparam int DEF_MAX_LISTS = 16;
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UP,
    ST_LOAD,
    ST_DOWN
  } state_t;

  typedef enum logic [1:0] {
    EMIT_TOP,
    EMIT_FINAL,
    EMIT_EMPTY
  } emit_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] key;
    logic [SRC_W-1:0] src;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic replace;
    logic pop;
    logic load;
    logic step_up;
    logic step_down;
    logic emit;
    emit_t emit_kind;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_one;
    logic up_done;
    logic down_done;
    logic [SRC_W-1:0] top_src;
  } status_t;

  // Heap order: smaller key first, equal keys by lower source index.
  function automatic logic entry_before(entry_t a, entry_t b);
    logic r;
    if (a.key != b.key) begin
      r = $signed(a.key) < $signed(b.key);
    end else begin
      r = a.src < b.src;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/kwm_datapath.sv @@
`default_nettype none

module kwm_datapath #(
  parameter int MAX_LISTS = kwm_pkg::DEF_MAX_LISTS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire kwm_pkg::cmd_t                     cmd,
  input  wire logic [kwm_pkg::SRC_W-1:0]         in_source,
  input  wire logic signed [kwm_pkg::VAL_W-1:0]  in_value,
  output kwm_pkg::status_t                       status,
  output logic                                   done,
  output logic signed [kwm_pkg::VAL_W-1:0]       out_value,
  output logic [kwm_pkg::SRC_W-1:0]              from_list,
  output logic                                   final_res,
  output logic                                   empty_merge
);
  import kwm_pkg::*;

  localparam int DEPTH = (MAX_LISTS < SRC_SPAN) ? MAX_LISTS : SRC_SPAN;
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MEM_DEPTH = 1 << IW;
  localparam int KW = IW + 2;

  entry_t mem [MEM_DEPTH];
  entry_t rd_a, rd_b;
  entry_t carry, carry_next;
  entry_t top, top_now;
  entry_t wdata, in_entry, best_l, best;

  logic [IW-1:0] hole, hole_next, raddr_a, raddr_b, waddr, parent, best_idx;
  logic [IW:0]   child_l, child_r;
  logic [CW-1:0] heap_count, heap_count_next;
  logic [KW-1:0] left_idx, right_idx;
  logic          we, left_ok, right_ok, take_left, take_right, up_done, down_done;

  assign in_entry = '{key: in_value, src: in_source};

  // One level of sift-down: pick the smallest of the carried entry and the
  // two children read in the previous cycle.
  always_comb begin
    left_idx   = {1'b0, hole, 1'b1};
    right_idx  = left_idx + KW'(1);
    left_ok    = left_idx < KW'(heap_count);
    right_ok   = right_idx < KW'(heap_count);
    take_left  = left_ok && entry_before(rd_a, carry);
    best_l     = take_left ? rd_a : carry;
    take_right = right_ok && entry_before(rd_b, best_l);
    best       = take_right ? rd_b : best_l;
    best_idx   = take_right ? right_idx[IW-1:0] : left_idx[IW-1:0];
    down_done  = !(take_left || take_right);
    child_l    = {best_idx, 1'b1};
    child_r    = child_l + (IW + 1)'(1);
    parent     = (hole - IW'(1)) >> 1;
    up_done    = (hole == '0) || !entry_before(carry, rd_a);
  end

  always_comb begin
    we              = 1'b0;
    waddr           = hole;
    wdata           = carry;
    hole_next       = hole;
    carry_next      = carry;
    heap_count_next = heap_count;
    raddr_a         = '0;
    raddr_b         = '0;
    if (cmd.clear) begin
      heap_count_next = '0;
    end
    if (cmd.push) begin
      carry_next      = in_entry;
      hole_next       = heap_count[IW-1:0];
      heap_count_next = heap_count + CW'(1);
      raddr_a         = (heap_count[IW-1:0] - IW'(1)) >> 1;
    end
    if (cmd.replace) begin
      carry_next = in_entry;
      hole_next  = '0;
      raddr_a    = IW'(1);
      raddr_b    = IW'(2);
    end
    if (cmd.pop) begin
      heap_count_next = heap_count - CW'(1);
      raddr_a         = IW'(heap_count - CW'(1));
    end
    if (cmd.load) begin
      carry_next = rd_a;
      hole_next  = '0;
      raddr_a    = IW'(1);
      raddr_b    = IW'(2);
    end
    if (cmd.step_up) begin
      we = 1'b1;
      if (up_done) begin
        wdata = carry;
      end else begin
        wdata     = rd_a;
        hole_next = parent;
        raddr_a   = (parent - IW'(1)) >> 1;
      end
    end
    if (cmd.step_down) begin
      we = 1'b1;
      if (down_done) begin
        wdata = carry;
      end else begin
        wdata     = best;
        hole_next = best_idx;
        raddr_a   = child_l[IW-1:0];
        raddr_b   = child_r[IW-1:0];
      end
    end
    top_now = (we && waddr == '0) ? wdata : top;
  end

  assign status.count_zero = (heap_count == '0);
  assign status.count_one  = (heap_count == CW'(1));
  assign status.up_done    = up_done;
  assign status.down_done  = down_done;
  assign status.top_src    = top_now.src;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_count <= '0;
      done       <= 1'b0;
    end else begin
      heap_count <= heap_count_next;
      done       <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    carry <= carry_next;
    hole  <= hole_next;
    top   <= top_now;
    if (cmd.emit) begin
      case (cmd.emit_kind)
        EMIT_TOP: begin
          out_value   <= top_now.key;
          from_list   <= top_now.src;
          final_res   <= 1'b0;
          empty_merge <= 1'b0;
        end
        EMIT_FINAL: begin
          out_value   <= '0;
          from_list   <= in_source;
          final_res   <= 1'b1;
          empty_merge <= 1'b0;
        end
        EMIT_EMPTY: begin
          out_value   <= '0;
          from_list   <= '0;
          final_res   <= 1'b1;
          empty_merge <= 1'b1;
        end
        default: begin
          out_value   <= '0;
          from_list   <= '0;
          final_res   <= 1'b0;
          empty_merge <= 1'b0;
        end
      endcase
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (heap_count < CW'(DEPTH)))
    else $error("push into a full heap");

  a_sift_deeper: assert property (@(posedge clk) disable iff (rst)
    (cmd.step_down && !status.down_done) |=> (hole > $past(hole)))
    else $error("sift-down did not move to a child");

endmodule

`default_nettype wire

@@ hdl/kwm_ctrl.sv @@
`default_nettype none

module kwm_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        restart,
  input  wire logic                        start,
  input  wire logic [kwm_pkg::SRC_W-1:0]   source,
  input  wire logic                        no_more,
  input  wire logic [kwm_pkg::CFG_W-1:0]   lists,
  input  wire kwm_pkg::status_t            status,
  output logic                             busy,
  output kwm_pkg::cmd_t                    cmd
);
  import kwm_pkg::*;

  state_t            state, state_next;
  logic              merging, merging_next;
  logic              fill_last, fill_last_next;
  logic [CFG_W-1:0]  fill_count, fill_count_next;
  logic [SRC_W-1:0]  awaited, awaited_next;
  logic              accept, fill_hit, merge_hit, last_fill;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && (state == ST_IDLE);
  assign fill_hit  = !merging && (fill_count == CFG_W'(source));
  assign merge_hit = merging && (awaited == source);
  assign last_fill = (fill_count + CFG_W'(1)) == lists;

  always_comb begin
    state_next      = state;
    merging_next    = merging;
    fill_last_next  = fill_last;
    fill_count_next = fill_count;
    awaited_next    = awaited;
    if (restart) begin
      state_next      = ST_IDLE;
      merging_next    = 1'b0;
      fill_count_next = '0;
      awaited_next    = '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && fill_hit) begin
            fill_count_next = fill_count + CFG_W'(1);
            if (!no_more) begin
              state_next     = ST_UP;
              fill_last_next = last_fill;
            end else if (last_fill) begin
              fill_count_next = '0;
              if (!status.count_zero) begin
                merging_next = 1'b1;
                awaited_next = status.top_src;
              end
            end
          end else if (accept && merge_hit) begin
            if (!no_more) begin
              state_next = ST_DOWN;
            end else if (status.count_one) begin
              merging_next = 1'b0;
              awaited_next = '0;
            end else begin
              state_next = ST_LOAD;
            end
          end
        end
        ST_UP: begin
          if (status.up_done) begin
            state_next = ST_IDLE;
            if (fill_last) begin
              merging_next    = 1'b1;
              fill_count_next = '0;
              awaited_next    = status.top_src;
            end
          end
        end
        ST_LOAD: begin
          state_next = ST_DOWN;
        end
        ST_DOWN: begin
          if (status.down_done) begin
            state_next   = ST_IDLE;
            awaited_next = status.top_src;
          end
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.emit_kind = EMIT_TOP;
    if (restart) begin
      cmd.clear = 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && fill_hit) begin
            if (!no_more) begin
              cmd.push = 1'b1;
            end else if (last_fill) begin
              cmd.emit = 1'b1;
              if (status.count_zero) begin
                cmd.emit_kind = EMIT_EMPTY;
                cmd.clear     = 1'b1;
              end
            end
          end else if (accept && merge_hit) begin
            if (!no_more) begin
              cmd.replace = 1'b1;
            end else if (status.count_one) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = EMIT_FINAL;
              cmd.clear     = 1'b1;
            end else begin
              cmd.pop = 1'b1;
            end
          end
        end
        ST_UP: begin
          cmd.step_up = 1'b1;
          cmd.emit    = status.up_done && fill_last;
        end
        ST_LOAD: begin
          cmd.load = 1'b1;
        end
        ST_DOWN: begin
          cmd.step_down = 1'b1;
          cmd.emit      = status.down_done;
        end
        default: begin
          cmd.clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      merging    <= 1'b0;
      fill_last  <= 1'b0;
      fill_count <= '0;
      awaited    <= '0;
    end else begin
      state      <= state_next;
      merging    <= merging_next;
      fill_last  <= fill_last_next;
      fill_count <= fill_count_next;
      awaited    <= awaited_next;
    end
  end

  a_load_then_down: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && !restart) |=> (state == ST_DOWN))
    else $error("last entry load not followed by sift-down");

  a_top_not_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.emit_kind == EMIT_TOP) |-> !status.count_zero)
    else $error("heap top emitted from an empty heap");

endmodule

`default_nettype wire

@@ hdl/k_way_sorted_merge.sv @@
// Results: the closing and empty results, and the first result when an end mark closes the
// fill phase, come in the cycle after the accepting edge; any other result waits for the heap
// sift, which visits one heap level after another, after first fetching the last entry on an
// end mark. Busy stays high during the sift, so no new item is taken until it ends.
// Reset (synchronous, active high) clears control state and sets active_lists to 16;
// heap contents are left as they are. Results cannot be stalled by the receiver.
`default_nettype none

module k_way_sorted_merge #(
  parameter int MAX_LISTS = kwm_pkg::DEF_MAX_LISTS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [kwm_pkg::SRC_W-1:0]         source,
  input  wire logic signed [kwm_pkg::VAL_W-1:0]  value,
  input  wire logic                              no_more,
  output logic                                   done,
  output logic signed [kwm_pkg::VAL_W-1:0]       out_value,
  output logic [kwm_pkg::SRC_W-1:0]              from_list,
  output logic                                   final_res,
  output logic                                   empty_merge,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [2:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import kwm_pkg::*;

  // The heap never holds more entries than lists can be addressed by source.
  localparam int DEPTH = (MAX_LISTS < SRC_SPAN) ? MAX_LISTS : SRC_SPAN;
  localparam logic REG_ACTIVE_LISTS = 1'b0;

  logic [CFG_W-1:0] active_lists;
  logic [CFG_W-1:0] lists;
  logic             cfg_write;
  cmd_t             cmd;
  status_t          status;

  // The APB port always completes in its access phase. Word addresses beyond
  // the single register read as zero and ignore writes.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == REG_ACTIVE_LISTS);
  assign prdata    = (paddr[2] == REG_ACTIVE_LISTS) ? 32'(active_lists) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_lists <= ACTIVE_RESET;
    end else if (cfg_write) begin
      active_lists <= pwdata[CFG_W-1:0];
    end
  end

  // Number of lists actually merged: zero behaves as one, and anything above
  // the heap depth is held to the depth.
  always_comb begin
    if (active_lists == '0) begin
      lists = CFG_W'(1);
    end else if (active_lists > CFG_W'(DEPTH)) begin
      lists = CFG_W'(DEPTH);
    end else begin
      lists = active_lists;
    end
  end

  // A register write abandons any merge in progress and starts a fresh fill
  // phase, so the controller and the heap count are cleared together.
  kwm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_write),
    .start   (start),
    .source  (source),
    .no_more (no_more),
    .lists   (lists),
    .status  (status),
    .busy    (busy),
    .cmd     (cmd)
  );

  // The datapath keeps the heap in a small memory with one write and two
  // registered reads, so a sift moves on level by level: the children of the next
  // hole (its parent, when sifting up) are read while the current level is written back.
  kwm_datapath #(
    .MAX_LISTS (MAX_LISTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_source   (source),
    .in_value    (value),
    .status      (status),
    .done        (done),
    .out_value   (out_value),
    .from_list   (from_list),
    .final_res   (final_res),
    .empty_merge (empty_merge)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

// Test bench for the k-way sorted merge.
// Items go in through the start/busy command port, results come back on a one-cycle done strobe,
// and the list count is set through the APB-style register port. A model of the head heap runs
// alongside the block and queues the result that each accepted beat should cause. The checker
// compares every strobed result, field by field, with the oldest entry in that queue.
module tb_top;

  localparam int MAXL = kwm_pkg::DEF_MAX_LISTS;
  localparam logic [2:0] ACTIVE_LISTS_ADDR = 3'd0;  // register 0 at byte address 0
  localparam int SETTLE = 12;         // longer than the worst sift latency of the block
  localparam int TAIL = 20;
  localparam int MAX_LEN = 8;         // room for the longest list that the random merges build
  localparam int RANDOM_BEATS = 750;

  typedef struct {
    logic signed [kwm_pkg::VAL_W-1:0] out_value;
    logic [kwm_pkg::SRC_W-1:0] from_list;
    logic final_res;
    logic empty_merge;
  } merge_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [kwm_pkg::SRC_W-1:0] source = '0;
  logic signed [kwm_pkg::VAL_W-1:0] value = '0;
  logic no_more = 1'b0;
  logic done;
  logic signed [kwm_pkg::VAL_W-1:0] out_value;
  logic [kwm_pkg::SRC_W-1:0] from_list;
  logic final_res;
  logic empty_merge;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  k_way_sorted_merge dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .source(source),
    .value(value),
    .no_more(no_more),
    .done(done),
    .out_value(out_value),
    .from_list(from_list),
    .final_res(final_res),
    .empty_merge(empty_merge),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // Results that the heap model says are still to come, oldest first.
  merge_res_t merged_due[$];
  merge_res_t seen_want;
  int err_count = 0;
  int merge_beats = 0;   // list beats sent by the merges, noise not included
  bit calm = 1'b0;       // when set, the sender never idles

  // The model's own copy of the block: the heap of list heads, the fill and merge
  // bookkeeping, and the active_lists register.
  logic signed [kwm_pkg::VAL_W-1:0] head_keys[MAXL];
  logic [kwm_pkg::SRC_W-1:0] head_srcs[MAXL];
  int heap_n;
  int filled;
  bit merging;
  logic [kwm_pkg::SRC_W-1:0] awaited;
  logic [kwm_pkg::CFG_W-1:0] lists_reg;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // A register value of 0 counts as one list; anything past what source can name is clipped.
  function automatic int lists_in_use();
    int n;
    n = int'(lists_reg);
    if (n < 1) n = 1;
    if (n > MAXL) n = MAXL;
    if (n > kwm_pkg::SRC_SPAN) n = kwm_pkg::SRC_SPAN;
    return n;
  endfunction

  // Smaller key leaves first; on a tie the lower list index wins.
  function automatic bit heads_order(input int i, input int j);
    if (head_keys[i] != head_keys[j]) return head_keys[i] < head_keys[j];
    return head_srcs[i] < head_srcs[j];
  endfunction

  task automatic heads_swap(input int i, input int j);
    logic signed [kwm_pkg::VAL_W-1:0] k;
    logic [kwm_pkg::SRC_W-1:0] s;
    k = head_keys[i];
    s = head_srcs[i];
    head_keys[i] = head_keys[j];
    head_srcs[i] = head_srcs[j];
    head_keys[j] = k;
    head_srcs[j] = s;
  endtask

  task automatic heads_push(input logic signed [kwm_pkg::VAL_W-1:0] k,
                            input logic [kwm_pkg::SRC_W-1:0] s);
    int i;
    int p;
    if (heap_n >= MAXL) return;
    i = heap_n;
    heap_n++;
    head_keys[i] = k;
    head_srcs[i] = s;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!heads_order(i, p)) break;
      heads_swap(i, p);
      i = p;
    end
  endtask

  task automatic heads_sift_down();
    int i;
    int l;
    int r;
    int m;
    bit moving;
    i = 0;
    moving = 1'b1;
    while (moving) begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      if (l < heap_n && heads_order(l, m)) m = l;
      if (r < heap_n && heads_order(r, m)) m = r;
      if (m == i) begin
        moving = 1'b0;
      end else begin
        heads_swap(i, m);
        i = m;
      end
    end
  endtask

  // Back to the fill phase. Heap entries are left alone: only those below heap_n are read.
  task automatic merge_restart();
    heap_n = 0;
    filled = 0;
    merging = 1'b0;
    awaited = '0;
  endtask

  task automatic due_push(input logic signed [kwm_pkg::VAL_W-1:0] v,
                          input logic [kwm_pkg::SRC_W-1:0] s, input logic fin, input logic emp);
    merge_res_t r;
    r.out_value = v;
    r.from_list = s;
    r.final_res = fin;
    r.empty_merge = emp;
    merged_due = {merged_due, r};
  endtask

  // Works out what one accepted beat does to the block and queues the result, if any.
  task automatic merge_predict(input logic [kwm_pkg::SRC_W-1:0] s,
                               input logic signed [kwm_pkg::VAL_W-1:0] v, input logic nm);
    if (!merging) begin
      // Fill phase: heads are taken strictly in list order, anything else is dropped.
      if (s != filled) return;
      if (!nm) heads_push(v, s);
      filled++;
      if (filled < lists_in_use()) return;
      if (heap_n == 0) begin
        // Every list was empty: a single closing result flagged as an empty merge.
        due_push('0, '0, 1'b1, 1'b1);
        merge_restart();
        return;
      end
      merging = 1'b1;
      awaited = head_srcs[0];
      due_push(head_keys[0], head_srcs[0], 1'b0, 1'b0);
    end else begin
      // Merge phase: only the list that supplied the last element may speak.
      if (s != awaited) return;
      if (heap_n == 0) begin
        merge_restart();
        return;
      end
      if (!nm) begin
        head_keys[0] = v;
        head_srcs[0] = s;
      end else begin
        heap_n--;
        head_keys[0] = head_keys[heap_n];
        head_srcs[0] = head_srcs[heap_n];
      end
      if (heap_n == 0) begin
        // The last list has ended, so the element sent before was the last one.
        due_push('0, s, 1'b1, 1'b0);
        merge_restart();
        return;
      end
      heads_sift_down();
      awaited = head_srcs[0];
      due_push(head_keys[0], head_srcs[0], 1'b0, 1'b0);
    end
  endtask

  // Sends one item. Start is left high on return, so that a following item can go out
  // on the very next edge; the sender's random idling lowers it when it idles.
  task automatic send_item(input logic [kwm_pkg::SRC_W-1:0] s, input logic [31:0] v,
                           input logic nm);
    while (!calm && $urandom_range(99) < 24) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    source <= s;
    value <= v;
    no_more <= nm;
    do @(posedge clk); while (busy);
    merge_predict(s, v, nm);
  endtask

  // One APB transfer to the active_lists register: the setup phase, then the access phase.
  task automatic apb_beat(input logic wr, input logic [31:0] wd, output logic [31:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ACTIVE_LISTS_ADDR;
    pwdata <= wd;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes active_lists once the block has gone quiet, then reads it back. A dropped
  // item gives no result, so after the last result the settling time is waited out as well.
  task automatic write_cfg(input logic [kwm_pkg::CFG_W-1:0] n);
    logic [31:0] wd;
    logic [31:0] rd;
    start <= 1'b0;
    while (merged_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (busy) @(posedge clk);
    wd = $urandom;
    wd[kwm_pkg::CFG_W-1:0] = n;
    apb_beat(1'b1, wd, rd);
    lists_reg = n;
    merge_restart();
    apb_beat(1'b0, '0, rd);
    if (rd !== {{(32 - kwm_pkg::CFG_W){1'b0}}, n})
      report_mismatch("active_lists read", rd, 32'(n));
  endtask

  // Register settings for the random part: half the time an extreme, otherwise a plain count.
  function automatic logic [kwm_pkg::CFG_W-1:0] pick_lists();
    logic [kwm_pkg::CFG_W-1:0] n;
    case ($urandom_range(0, 7))
      0: n = '0;
      1: n = 5'd1;
      2: n = 5'd16;
      3: n = 5'($urandom_range(17, 31));
      default: n = 5'($urandom_range(2, 16));
    endcase
    return n;
  endfunction

  // One whole merge of freshly built ascending lists, driven the way the block asks for it:
  // the heads in list order, then always the list named by the last result. Now and then a
  // beat from the wrong list, an element out of order, or an abort by a register write is
  // mixed in.
  task automatic run_merge();
    logic signed [kwm_pkg::VAL_W-1:0] elems[MAXL][MAX_LEN];
    int len[MAXL];
    int pos[MAXL];
    logic signed [kwm_pkg::VAL_W-1:0] v;
    logic [kwm_pkg::SRC_W-1:0] tgt;
    logic [kwm_pkg::SRC_W-1:0] stray;
    logic nm;
    int mode;
    int j;
    int steps;
    int abort_at;
    int off;
    mode = $urandom_range(0, 2);
    for (int s = 0; s < MAXL; s++) begin
      len[s] = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 5);
      pos[s] = 0;
      for (int k = 0; k < len[s]; k++) begin
        // A narrow range gives plenty of ties, the full range reaches every bit.
        if (mode == 0) begin
          v = $urandom_range(0, 6);
          v = v - 3;
        end else if (mode == 1) begin
          v = $urandom;
        end else begin
          case ($urandom_range(0, 6))
            0: v = 32'sh8000_0000;
            1: v = 32'sh8000_0001;
            2: v = -1;
            3: v = 0;
            4: v = 1;
            5: v = 32'sh7FFF_FFFE;
            default: v = 32'sh7FFF_FFFF;
          endcase
        end
        j = k;
        while (j > 0 && elems[s][j-1] > v) begin
          elems[s][j] = elems[s][j-1];
          j--;
        end
        elems[s][j] = v;
      end
    end
    abort_at = ($urandom_range(99) < 12) ? $urandom_range(1, 20) : -1;
    steps = 0;
    do begin
      tgt = merging ? awaited : filled[kwm_pkg::SRC_W-1:0];
      if ($urandom_range(99) < 8) begin
        off = $urandom_range(1, kwm_pkg::SRC_SPAN - 1);
        stray = tgt + off[kwm_pkg::SRC_W-1:0];
        send_item(stray, $urandom, 1'($urandom_range(0, 1)));
      end
      if (pos[tgt] < len[tgt]) begin
        v = elems[tgt][pos[tgt]];
        pos[tgt]++;
        nm = 1'b0;
      end else begin
        v = $urandom;   // ignored beside an end mark
        nm = 1'b1;
      end
      if ($urandom_range(99) < 3) v = $urandom;
      send_item(tgt, v, nm);
      merge_beats++;
      steps++;
    end while ((merging || filled != 0) && steps != abort_at);
    if (steps == abort_at && (merging || filled != 0)) write_cfg(pick_lists());
  endtask

  task automatic test_reset_value();
    logic [31:0] rd;
    apb_beat(1'b0, '0, rd);
    if (rd !== {{(32 - kwm_pkg::CFG_W){1'b0}}, kwm_pkg::ACTIVE_RESET})
      report_mismatch("active_lists after reset", rd, 32'(kwm_pkg::ACTIVE_RESET));
  endtask

  // A single list: both extremes of the value, the second one out of order, then the
  // closing result; after that a merge in which the only list is empty.
  task automatic test_single_list();
    write_cfg(5'd1);
    send_item(4'd0, 32'h7FFF_FFFF, 1'b0);
    send_item(4'd0, 32'h8000_0000, 1'b0);
    send_item(4'd0, 32'h0000_0000, 1'b1);
    send_item(4'd0, 32'hFFFF_FFFF, 1'b1);
  endtask

  // A register value of zero behaves as a single list.
  task automatic test_zero_lists();
    write_cfg(5'd0);
    send_item(4'd0, 32'h0000_0000, 1'b0);
    send_item(4'd0, 32'hAAAA_AAAA, 1'b1);
  endtask

  // Two lists: a head out of turn in the fill phase, equal heads, and a beat from the
  // wrong list while merging.
  task automatic test_order_and_ties();
    write_cfg(5'd2);
    send_item(4'd1, 32'd5, 1'b0);
    send_item(4'd0, -32'sd5, 1'b0);
    send_item(4'd1, -32'sd5, 1'b0);
    send_item(4'd1, 32'd9, 1'b0);
    send_item(4'd0, -32'sd5, 1'b0);
    send_item(4'd0, 32'h5555_5555, 1'b1);
    send_item(4'd1, 32'hFFFF_FFFF, 1'b1);
  endtask

  // Register writes in the middle of a fill and in the middle of a merge start over.
  task automatic test_abort();
    write_cfg(5'd16);
    send_item(4'd0, 32'd1, 1'b0);
    send_item(4'd1, 32'd2, 1'b0);
    send_item(4'd2, 32'd3, 1'b0);
    write_cfg(5'd3);
    send_item(4'd0, 32'd10, 1'b0);
    send_item(4'd1, 32'd0, 1'b1);
    send_item(4'd2, 32'd0, 1'b1);
    write_cfg(5'd2);
    send_item(4'd0, 32'd0, 1'b1);
    send_item(4'd1, 32'd0, 1'b1);
  endtask

  // The first stretch runs with no idling at all, the rest with random gaps.
  task automatic test_random_merges();
    calm = 1'b1;
    while (merge_beats < RANDOM_BEATS) begin
      if (merge_beats > 220) calm = 1'b0;
      if ($urandom_range(99) < 50) write_cfg(pick_lists());
      run_merge();
    end
    calm = 1'b0;
  endtask

  // Results are strobed for one cycle and cannot be held off, so every done seen at an
  // edge is a result that has been delivered and must match the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (merged_due.size() == 0) begin
        report_mismatch("result with nothing due", out_value, '0);
      end else begin
        seen_want = merged_due.pop_front();
        if (out_value !== seen_want.out_value)
          report_mismatch("out_value", out_value, seen_want.out_value);
        if (from_list !== seen_want.from_list)
          report_mismatch("from_list", 32'(from_list), 32'(seen_want.from_list));
        if (final_res !== seen_want.final_res)
          report_mismatch("final_res", 32'(final_res), 32'(seen_want.final_res));
        if (empty_merge !== seen_want.empty_merge)
          report_mismatch("empty_merge", 32'(empty_merge), 32'(seen_want.empty_merge));
      end
    end
  end

  initial begin
    lists_reg = kwm_pkg::ACTIVE_RESET;
    merge_restart();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_value();
    test_single_list();
    test_zero_lists();
    test_order_and_ties();
    test_abort();
    test_random_merges();
    start <= 1'b0;
    while (merged_due.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every beat of the tests taken at the slowest sift, plus
  // the random gaps and the settling before every register write.
  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
